/* rtl/gilbert_moore_code_builder_encoder_assert.svh */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef GILBERT_MOORE_CODE_BUILDER_ENCODER_ASSERT_SVH
`define GILBERT_MOORE_CODE_BUILDER_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GMCBE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GMCBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GMCBE_ASSERT_SAME(label, ante, cons, msg)
`define GMCBE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/gmcbe_pkg.sv */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder package
// Shared codes, widths and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package gmcbe_pkg;

	localparam int SYM_W   = 8;
	localparam int CODE_W  = 25;
	localparam int LEN_W   = 5;
	localparam int MAX_LEN = 25;
	// flips a raw byte into its place in signed byte order
	localparam logic [SYM_W-1:0] SLOT_FLIP = 8'h80;

	typedef enum logic [1:0] {
		ACT_COUNT  = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef struct packed {
		logic hist_rd;
		logic hist_inc;
		logic clear;
		logic tbl_rd;
		logic out_load;
		logic bld_start;
		logic bld_rd;
		logic bld_load;
		logic len_step;
		logic bits_init;
		logic bits_step;
		logic tbl_wr;
	} cmd_t;

	typedef struct packed {
		logic len_done;
		logic bits_done;
		logic slot_last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/gmcbe_ctrl.sv */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder controller
// Sequences count, encode and clear items and the code construction burst.
// ----------------------------------------------------------------------------
module gmcbe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       action,
	input  logic             last,
	output logic             in_stall,
	output gmcbe_pkg::cmd_t  cmd,
	input  gmcbe_pkg::sts_t  sts
);
	import gmcbe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CNT_WR,
		S_ENC,
		S_B_START,
		S_B_RD,
		S_B_LOAD,
		S_B_LEN,
		S_B_BITS
	} state_t;

	state_t state_q, state_d;
	logic   last_q;

	assign in_stall = (state_q != S_IDLE);

	// decode state into datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(action))
						ACT_COUNT: begin
							cmd.hist_rd = 1'b1;
							state_d     = S_CNT_WR;
						end
						ACT_ENCODE: begin
							cmd.tbl_rd = 1'b1;
							state_d    = S_ENC;
						end
						ACT_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_CNT_WR: begin
				cmd.hist_inc = 1'b1;
				state_d      = last_q ? S_B_START : S_IDLE;
			end
			S_ENC: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_B_START: begin
				cmd.bld_start = 1'b1;
				state_d       = S_B_RD;
			end
			S_B_RD: begin
				cmd.bld_rd = 1'b1;
				state_d    = S_B_LOAD;
			end
			S_B_LOAD: begin
				cmd.bld_load = 1'b1;
				state_d      = S_B_LEN;
			end
			S_B_LEN: begin
				if (sts.len_done) begin
					cmd.bits_init = 1'b1;
					state_d       = S_B_BITS;
				end else begin
					cmd.len_step = 1'b1;
				end
			end
			S_B_BITS: begin
				if (sts.bits_done) begin
					cmd.tbl_wr = 1'b1;
					state_d    = sts.slot_last ? S_IDLE : S_B_RD;
				end else begin
					cmd.bits_step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and the last flag of the item in hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid) begin
				last_q <= last;
			end
		end
	end

endmodule

/* rtl/gmcbe_dpath.sv */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder datapath
// Histogram memory, code tables, length search and bit-serial code division.
// ----------------------------------------------------------------------------
`include "gilbert_moore_code_builder_encoder_assert.svh"

module gmcbe_dpath #(
	parameter int SYMBOL_COUNT = 256,
	parameter int COUNT_BITS   = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [gmcbe_pkg::SYM_W-1:0]          symbol,
	input  gmcbe_pkg::cmd_t                      cmd,
	output gmcbe_pkg::sts_t                      sts,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gmcbe_pkg::CODE_W-1:0]         codeword,
	output logic [gmcbe_pkg::LEN_W-1:0]          code_length,
	output logic                                 present
);
	import gmcbe_pkg::*;

	localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CW = COUNT_BITS + 1;
	localparam int NW = COUNT_BITS + 2;

	logic [COUNT_BITS-1:0] hist_mem [SYMBOL_COUNT];
	logic [CODE_W-1:0]     code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]      len_mem  [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] hist_vld_q;

	logic [SYM_W-1:0]      slot_in;
	logic                  in_range;
	logic [SW-1:0]         rd_addr;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] hist_rd_q;
	logic                  hist_rdv_q;
	logic [COUNT_BITS-1:0] hist_cur;
	logic [SW-1:0]         cnt_slot_q;
	logic                  cnt_ok_q;
	logic                  inc_en;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] cum_q;
	logic [SW-1:0]         bslot_q;
	logic [COUNT_BITS-1:0] c_q;
	logic [CW-1:0]         csh_q;
	logic [LEN_W-1:0]      k_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      i_q;
	logic [NW-1:0]         num_q;
	logic [NW-1:0]         num_dbl;
	logic [NW-1:0]         den;
	logic [CODE_W-1:0]     bits_q;
	logic                  absent;
	logic [CODE_W-1:0]     code_rd_q;
	logic [LEN_W-1:0]      len_rd_q;
	logic                  enc_ok_q;
	logic [LEN_W-1:0]      enc_len;
	logic                  ready_q;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     out_code_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_pres_q;

	// place the byte in signed order and check it against the alphabet
	assign slot_in  = symbol ^ SLOT_FLIP;
	assign in_range = ({1'b0, slot_in} < (SYM_W+1)'(SYMBOL_COUNT));
	assign rd_addr  = cmd.bld_rd ? bslot_q : slot_in[SW-1:0];
	assign rd_en    = cmd.hist_rd | cmd.bld_rd;
	assign hist_cur = hist_rdv_q ? hist_rd_q : '0;
	assign inc_en   = cmd.hist_inc & cnt_ok_q & (total_q != '1);

	// histogram memory: registered read, increment write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			hist_rd_q  <= hist_mem[rd_addr];
			hist_rdv_q <= hist_vld_q[rd_addr];
		end
		if (cmd.hist_rd) begin
			cnt_slot_q <= slot_in[SW-1:0];
			cnt_ok_q   <= in_range;
		end
		if (inc_en) begin
			hist_mem[cnt_slot_q] <= hist_cur + 1'b1;
		end
	end

	// length search and code division
	assign absent  = (c_q == '0) || (total_q == '0);
	assign num_dbl = {num_q[NW-2:0], 1'b0};
	assign den     = {1'b0, total_q, 1'b0};

	assign sts.len_done  = absent || !((csh_q < {1'b0, total_q}) &&
		(k_q < LEN_W'(MAX_LEN - 1)));
	assign sts.bits_done = (i_q == len_q);
	assign sts.slot_last = (bslot_q == SW'(SYMBOL_COUNT - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.bld_load) begin
			c_q   <= hist_cur;
			csh_q <= {1'b0, hist_cur};
			k_q   <= '0;
		end
		if (cmd.len_step) begin
			csh_q <= {csh_q[CW-2:0], 1'b0};
			k_q   <= k_q + 1'b1;
		end
		if (cmd.bits_init) begin
			len_q  <= absent ? '0 : k_q + 1'b1;
			num_q  <= {1'b0, cum_q, 1'b0} + NW'(c_q);
			i_q    <= '0;
			bits_q <= '0;
		end
		if (cmd.bits_step) begin
			i_q <= i_q + 1'b1;
			if (num_dbl >= den) begin
				num_q  <= num_dbl - den;
				bits_q <= {bits_q[CODE_W-2:0], 1'b1};
			end else begin
				num_q  <= num_dbl;
				bits_q <= {bits_q[CODE_W-2:0], 1'b0};
			end
		end
	end

	// code and length tables: written by the build, read by encode items
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			code_mem[bslot_q] <= bits_q;
			len_mem[bslot_q]  <= len_q;
		end
		if (cmd.tbl_rd) begin
			code_rd_q <= code_mem[slot_in[SW-1:0]];
			len_rd_q  <= len_mem[slot_in[SW-1:0]];
			enc_ok_q  <= in_range & ready_q;
		end
	end

	// output register payload
	assign enc_len = enc_ok_q ? len_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_len_q  <= enc_len;
			out_code_q <= (enc_len != '0) ? code_rd_q : '0;
			out_pres_q <= (enc_len != '0);
		end
	end

	// control state: valid bits, totals, table ready, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q  <= '0;
			total_q     <= '0;
			cum_q       <= '0;
			bslot_q     <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				hist_vld_q <= '0;
				total_q    <= '0;
				cum_q      <= '0;
				ready_q    <= 1'b0;
			end
			if (inc_en) begin
				hist_vld_q[cnt_slot_q] <= 1'b1;
				total_q                <= total_q + 1'b1;
			end
			if (cmd.bld_start) begin
				cum_q   <= '0;
				bslot_q <= '0;
			end
			if (cmd.tbl_wr) begin
				cum_q   <= cum_q + c_q;
				bslot_q <= bslot_q + 1'b1;
				if (sts.slot_last) begin
					ready_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign codeword    = out_code_q;
	assign code_length = out_len_q;
	assign present     = out_pres_q;

	`GMCBE_ASSERT_NEXT(a_clear_empties, cmd.clear, !ready_q && total_q == '0, "clear left state")
	`GMCBE_ASSERT_NEXT(a_build_ready, cmd.tbl_wr && sts.slot_last, ready_q, "build not ready")
	`GMCBE_ASSERT_SAME(a_len_bound, cmd.tbl_wr, len_q <= LEN_W'(MAX_LEN), "code too long")
	`GMCBE_ASSERT_SAME(a_pres_len, out_valid_q, out_pres_q == (out_len_q != '0), "present mismatch")

endmodule

/* rtl/gilbert_moore_code_builder_encoder.sv */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder and encoder
// Byte histogram, Gilbert-Moore code construction and per-symbol encoding.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A count item reads the histogram memory,
// then writes the increment; a clear item is done in the idle state; an
// encode item reads the code tables, then waits for the output register to
// free up. A count item with last set is followed by the build burst, which
// starts once and then visits every symbol slot in turn: per slot a
// histogram read, a length search and a bit-serial division that gives one
// code bit per cycle.
module gilbert_moore_code_builder_encoder #(
	parameter int SYMBOL_COUNT = 256,
	parameter int COUNT_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  symbol,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [24:0] codeword,
	output logic [4:0]  code_length,
	output logic        present
);
	import gmcbe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gmcbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.last     (last),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	gmcbe_dpath #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.COUNT_BITS   (COUNT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (symbol),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.codeword    (codeword),
		.code_length (code_length),
		.present     (present)
	);

endmodule

/* test/tb_gilbert_moore_code_builder_encoder.sv */
// ----------------------------------------------------------------------------
// Gilbert-Moore code builder testbench
// Drives count, encode and clear items with bursty input and a stalling
// output. A local model builds the expected code tables and the results of
// encode items are checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_gilbert_moore_code_builder_encoder;
	import gmcbe_pkg::*;

	localparam int N_SYM     = 256;
	localparam int CNT_BITS  = 24;
	localparam logic [31:0] CNT_MAX = (32'd1 << CNT_BITS) - 1;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		action_t    act;
		logic [7:0] sym;
		logic       lst;
	} gm_item_t;

	typedef struct packed {
		logic [24:0] cw;
		logic [4:0]  len;
		logic        pres;
	} gm_code_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [7:0]  symbol;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [24:0] codeword;
	logic [4:0]  code_length;
	logic        present;

	gilbert_moore_code_builder_encoder #(
		.SYMBOL_COUNT(N_SYM),
		.COUNT_BITS(CNT_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .symbol(symbol), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.codeword(codeword), .code_length(code_length), .present(present)
	);

	// model state
	logic [31:0] sym_hist [N_SYM];
	logic [31:0] sym_total;
	logic [24:0] code_tbl [N_SYM];
	logic [4:0]  len_tbl [N_SYM];
	logic        tbl_ready;

	gm_item_t pending_items [$];
	gm_code_t expected_codes [$];
	int       fail_count;
	int       encodes_seen;
	int       builds_done;
	longint   cycle_count;
	bit       hold_off;
	int       burst_left;
	int       gap_left;
	int       stall_mode;
	int       in_accepts;
	int       in_popped;

	// empty the histogram and code tables
	task automatic clear_hist();
		for (int s = 0; s < N_SYM; s++) begin
			sym_hist[s] = 0;
			code_tbl[s] = 0;
			len_tbl[s] = 0;
		end
		sym_total = 0;
		tbl_ready = 0;
	endtask

	// build the code over slots in signed byte order
	task automatic build_codes();
		longint cum;
		longint c;
		longint num;
		longint den;
		int     ln;
		logic [24:0] bits;
		cum = 0;
		for (int s = 0; s < N_SYM; s++) begin
			c = sym_hist[s];
			code_tbl[s] = 0;
			len_tbl[s] = 0;
			if (c != 0 && sym_total != 0) begin
				ln = 0;
				while ((c << ln) < sym_total && ln < 40)
					ln++;
				ln = ln + 1;
				if (ln > MAX_LEN)
					ln = MAX_LEN;
				num = 2 * cum + c;
				den = 2 * longint'(sym_total);
				bits = 0;
				for (int k = 0; k < ln; k++) begin
					num = num << 1;
					bits = bits << 1;
					if (num >= den) begin
						num = num - den;
						bits[0] = 1'b1;
					end
				end
				code_tbl[s] = bits;
				len_tbl[s] = ln[4:0];
				cum = cum + c;
			end
		end
		tbl_ready = 1;
		builds_done++;
	endtask

	// advance the model by one accepted item
	task automatic predict_item(input gm_item_t it);
		logic [7:0] slot;
		gm_code_t   r;
		slot = it.sym ^ SLOT_FLIP;
		case (it.act)
			ACT_COUNT: begin
				if (sym_total < CNT_MAX) begin
					sym_hist[slot]++;
					sym_total++;
				end
				if (it.lst)
					build_codes();
			end
			ACT_ENCODE: begin
				r.len = tbl_ready ? len_tbl[slot] : 5'd0;
				r.cw = (r.len != 0) ? code_tbl[slot] : 25'd0;
				r.pres = (r.len != 0);
				expected_codes.push_back(r);
			end
			ACT_CLEAR: clear_hist();
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_count);
		fail_count++;
	endtask

	task automatic add_item(input action_t a, input logic [7:0] s, input logic l);
		gm_item_t it;
		it.act = a;
		it.sym = s;
		it.lst = l;
		pending_items.push_back(it);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: bursts and gaps, change on falling edge
	always @(negedge clk) begin
		bit took;
		if (arst_n) begin
			took = 1'b0;
			// drop the item that the monitor saw accepted
			if (in_popped != in_accepts) begin
				void'(pending_items.pop_front());
				in_popped++;
				took = 1'b1;
			end
			if (!in_valid || took) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (hold_off || pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else begin
					burst_left--;
					in_valid <= 1'b1;
					action <= pending_items[0].act;
					symbol <= pending_items[0].sym;
					last <= pending_items[0].lst;
				end
			end
			// receiver stall pattern
			if (cycle_count % 300 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= (cycle_count % 7 < 3);
			endcase
		end
	end

	// monitor: accept on rising edge
	always @(posedge clk) begin
		gm_code_t e;
		if (arst_n) begin
			cycle_count++;
			if (in_valid && !in_stall) begin
				predict_item('{act: action_t'(action), sym: symbol, lst: last});
				in_accepts++;
			end
			if (out_valid && !out_stall) begin
				encodes_seen++;
				if (expected_codes.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					e = expected_codes.pop_front();
					if (codeword !== e.cw)
						report("codeword", 32'(codeword), 32'(e.cw));
					if (code_length !== e.len)
						report("code_length", 32'(code_length), 32'(e.len));
					if (present !== e.pres)
						report("present", 32'(present), 32'(e.pres));
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout at cycle %0d", cycle_count);
				$display("gilbert_moore_code_builder_encoder verification failed");
				$finish;
			end
		end
	end

	// wait until the driver has nothing left and all results have come
	task automatic drain();
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_codes.size() != 0)
			@(posedge clk);
	endtask

	// queue one count pass with a random distribution then some encodes
	task automatic queue_pass(input int n_cnt, input int n_enc);
		logic [7:0] pool [4];
		int n_pool;
		n_pool = $urandom_range(1, 4);
		for (int i = 0; i < 4; i++)
			pool[i] = 8'($urandom);
		for (int i = 0; i < n_cnt; i++) begin
			if ($urandom_range(0, 15) == 0)
				add_item(action_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			else
				add_item(ACT_COUNT, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					pool[$urandom_range(0, n_pool - 1)], i == n_cnt - 1);
		end
		for (int i = 0; i < n_enc; i++)
			add_item(ACT_ENCODE, ($urandom_range(0, 1) == 0) ?
				pool[$urandom_range(0, n_pool - 1)] : 8'($urandom), 1'b0);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		action = ACT_COUNT;
		symbol = 0;
		last = 0;
		out_stall = 0;
		fail_count = 0;
		encodes_seen = 0;
		builds_done = 0;
		cycle_count = 0;
		hold_off = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		in_accepts = 0;
		in_popped = 0;
		clear_hist();
		builds_done = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: encode before any build, single-symbol build, extremes
		add_item(ACT_ENCODE, 8'h00, 1'b0);
		add_item(ACT_ENCODE, 8'hFF, 1'b1);
		add_item(ACT_CLEAR, 8'h00, 1'b1);
		add_item(ACT_COUNT, 8'h00, 1'b1);
		add_item(ACT_CLEAR, 8'h55, 1'b0);
		add_item(action_t'(2'd3), 8'hAA, 1'b1);
		add_item(ACT_COUNT, 8'h80, 1'b1);
		add_item(ACT_ENCODE, 8'h80, 1'b0);
		add_item(ACT_COUNT, 8'h7F, 1'b0);
		add_item(ACT_COUNT, 8'hFF, 1'b0);
		add_item(ACT_COUNT, 8'h00, 1'b0);
		add_item(ACT_COUNT, 8'h00, 1'b1);
		add_item(ACT_COUNT, 8'h01, 1'b0);
		add_item(ACT_ENCODE, 8'h80, 1'b0);
		add_item(ACT_ENCODE, 8'h7F, 1'b0);
		add_item(ACT_ENCODE, 8'hFF, 1'b0);
		add_item(ACT_ENCODE, 8'h00, 1'b0);
		add_item(ACT_ENCODE, 8'h01, 1'b0);
		add_item(ACT_CLEAR, 8'hFF, 1'b0);
		add_item(ACT_ENCODE, 8'h00, 1'b0);
		drain();

		// pause until every result is in, then random passes
		hold_off = 1;
		repeat (20) @(posedge clk);
		hold_off = 0;
		for (int p = 0; p < 27; p++) begin
			queue_pass($urandom_range(3, 18), $urandom_range(4, 14));
			if ($urandom_range(0, 2) == 0)
				add_item(ACT_CLEAR, 8'($urandom), 1'($urandom));
			if (p % 6 == 5) begin
				drain();
				hold_off = 1;
				repeat (10) @(posedge clk);
				hold_off = 0;
			end
		end
		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d code builds and %0d encode results", builds_done, encodes_seen);
		if (fail_count == 0)
			$display("gilbert_moore_code_builder_encoder verification clean");
		else
			$display("gilbert_moore_code_builder_encoder verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/gmcbe_pkg.sv
rtl/gmcbe_ctrl.sv
rtl/gmcbe_dpath.sv
rtl/gilbert_moore_code_builder_encoder.sv
test/tb_gilbert_moore_code_builder_encoder.sv
